// ===== hw/rtl/tic_pkg.sv =====
package tic_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DiffW  = 17;
  localparam int unsigned TripW  = 53;
  localparam int unsigned MomW   = 37;
  localparam int unsigned VolW   = 48;
  localparam int unsigned OutW   = 64;
  localparam int unsigned NumLanes = 6;
  // lane product width, triple product magnitude times moment magnitude
  localparam int unsigned ProdW  = 89;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex0_x;
    logic signed [CoordW-1:0] vertex0_y;
    logic signed [CoordW-1:0] vertex0_z;
    logic signed [CoordW-1:0] vertex1_x;
    logic signed [CoordW-1:0] vertex1_y;
    logic signed [CoordW-1:0] vertex1_z;
    logic signed [CoordW-1:0] vertex2_x;
    logic signed [CoordW-1:0] vertex2_y;
    logic signed [CoordW-1:0] vertex2_z;
    logic signed [CoordW-1:0] vertex3_x;
    logic signed [CoordW-1:0] vertex3_y;
    logic signed [CoordW-1:0] vertex3_z;
  } tic_in_t;

  typedef struct packed {
    logic signed [VolW-1:0] volume;
    logic signed [OutW-1:0] inertia_xx;
    logic signed [OutW-1:0] inertia_yy;
    logic signed [OutW-1:0] inertia_zz;
    logic signed [OutW-1:0] inertia_xy;
    logic signed [OutW-1:0] inertia_xz;
    logic signed [OutW-1:0] inertia_yz;
  } tic_out_t;

  // a vertex as three coordinates
  typedef logic signed [2:0][CoordW-1:0] tic_vec_t;

endpackage

// ===== hw/rtl/tic_div_const.sv =====
// pipelined floor(num/den) for a constant divisor by long division,
// four quotient bits per stage, of a non-negative value whose width is NumW
module tic_div_const import tic_pkg::*; #(
  parameter int unsigned NumW = 90,
  parameter int unsigned QW   = 64,
  parameter int unsigned Den  = 15
) (
  input  logic            clk_i,
  input  logic [NumW-1:0] num_i,
  output logic [QW-1:0]   quo_o
);
  // long division, four bits per stage, pipelined
  localparam int unsigned Steps  = (NumW + 3) / 4;
  localparam int unsigned PadW   = Steps * 4;
  localparam int unsigned RemW   = $clog2(Den) + 1;

  logic [PadW-1:0] num_q [Steps+1];
  logic [PadW-1:0] quo_q [Steps+1];
  logic [RemW-1:0] rem_q [Steps+1];

  assign num_q[0] = PadW'(num_i);
  assign quo_q[0] = '0;
  assign rem_q[0] = '0;

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [RemW+3:0] r_w;
    logic [3:0]      qd_w;
    always_comb begin
      qd_w = '0;
      r_w = {rem_q[s], num_q[s][PadW-1 -: 4]};
      for (int k = 15; k >= 1; k--) begin
        if (qd_w == '0 && r_w >= (RemW+4)'(k * Den)) qd_w = 4'(k);
      end
    end
    always_ff @(posedge clk_i) begin
      num_q[s+1] <= {num_q[s][PadW-5:0], 4'b0};
      quo_q[s+1] <= {quo_q[s][PadW-5:0], qd_w};
      rem_q[s+1] <= RemW'(r_w - (RemW+4)'(qd_w * Den));
    end
  end

  assign quo_o = QW'(quo_q[Steps]);
endmodule

// ===== hw/rtl/tic_lane.sv =====
// one covariance lane: moment times triple product, scaled by 1/120 in Q16
module tic_lane import tic_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [TripW-1:0]  trip_i,
  input  logic signed [MomW-1:0]   mom_i,
  output logic signed [OutW-1:0]   cov_o
);
  localparam int unsigned DivDepth = (ProdW - 27 + 3) / 4;

  logic [TripW-2:0] ta_q;
  logic [MomW-2:0]  mb_q;
  logic             neg_q;
  logic [ProdW-1:0] p0_q, p1_q;
  logic             neg1_q, neg2_q;
  logic [ProdW-28:0] y_q;
  logic [DivDepth-1:0] neg_sr_q;
  logic [OutW-1:0]  quo_w;

  // magnitudes
  always_ff @(posedge clk_i) begin
    ta_q  <= (TripW-1)'(trip_i[TripW-1] ? -trip_i : trip_i);
    mb_q  <= (MomW-1)'(mom_i[MomW-1] ? -mom_i : mom_i);
    neg_q <= trip_i[TripW-1] ^ mom_i[MomW-1];
  end

  // product in two partial halves, then sum
  logic [ProdW-1:0] plo_w, phi_w;
  assign plo_w = ProdW'(ta_q[25:0]) * ProdW'(mb_q);
  assign phi_w = ProdW'(ta_q[TripW-2:26]) * ProdW'(mb_q);
  always_ff @(posedge clk_i) begin
    p0_q   <= plo_w;
    p1_q   <= phi_w << 26;
    neg1_q <= neg_q;
  end

  // add rounding half of 120*2^24 and drop 2^27
  always_ff @(posedge clk_i) begin
    y_q    <= (ProdW-27)'((p0_q + p1_q + (ProdW'(15) << 26)) >> 27);
    neg2_q <= neg1_q;
  end

  tic_div_const #(.NumW(ProdW-27), .QW(OutW), .Den(15)) u_div (
    .clk_i (clk_i),
    .num_i (y_q),
    .quo_o (quo_w)
  );

  always_ff @(posedge clk_i) begin
    neg_sr_q <= {neg_sr_q[DivDepth-2:0], neg2_q};
  end
  assign cov_o = neg_sr_q[DivDepth-1] ? -quo_w : quo_w;
endmodule

// ===== hw/rtl/tetra_inertia_covariance.sv =====
// channel | signals                         | handshake
// input   | start_i, busy_o, item_i         | taken when start_i && !busy_o
// result  | done_o, result_o                | one cycle, no stall
// config  | cfg_we_i, cfg_wdata_i           | written when cfg_we_i
// one item per cycle, busy_o is always low; a result leaves after the
// accepting edge through two front stages, three lane stages, sixteen stages of
// the divide by 15 (one 4-bit quotient digit each) and the merge register.
// reset clears the valid pipeline and sets absolute volume mode; the
// receiver cannot stall.
module tetra_inertia_covariance import tic_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  tic_in_t  item_i,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  output logic     done_o,
  output tic_out_t result_o
);
  localparam int unsigned DivDepth = (ProdW - 27 + 3) / 4;
  localparam int unsigned LaneLat  = 3 + DivDepth;
  localparam int unsigned Lat      = 3 + LaneLat;

  logic abs_q;
  logic [Lat-1:0] vld_q;
  tic_vec_t v_w [4];
  logic signed [DiffW-1:0] d_w [3][3];
  logic signed [2*DiffW+1:0] cr_q [3];
  logic signed [DiffW-1:0] d0_q [3];
  logic signed [TripW-1:0] t_w, t_q;
  logic signed [MomW-1:0] m_q [NumLanes], m2_q [NumLanes];
  logic signed [OutW-1:0] c_w [NumLanes];

  assign busy_o = 1'b0;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) abs_q <= 1'b1;
    else if (cfg_we_i) abs_q <= cfg_wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[Lat-2:0], start_i};
  end

  assign v_w[0] = {item_i.vertex0_x, item_i.vertex0_y, item_i.vertex0_z};
  assign v_w[1] = {item_i.vertex1_x, item_i.vertex1_y, item_i.vertex1_z};
  assign v_w[2] = {item_i.vertex2_x, item_i.vertex2_y, item_i.vertex2_z};
  assign v_w[3] = {item_i.vertex3_x, item_i.vertex3_y, item_i.vertex3_z};

  // edge vectors; index 2 is x, 0 is z in the packed vector
  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int a = 0; a < 3; a++)
        d_w[i][a] = DiffW'($signed(v_w[i][2-a])) - DiffW'($signed(v_w[3][2-a]));
  end

  // stage 1: cross product and moment sums
  always_ff @(posedge clk_i) begin
    cr_q[0] <= 36'(d_w[1][1] * d_w[2][2]) - 36'(d_w[1][2] * d_w[2][1]);
    cr_q[1] <= 36'(d_w[1][2] * d_w[2][0]) - 36'(d_w[1][0] * d_w[2][2]);
    cr_q[2] <= 36'(d_w[1][0] * d_w[2][1]) - 36'(d_w[1][1] * d_w[2][0]);
    for (int a = 0; a < 3; a++) d0_q[a] <= d_w[0][a];
  end

  // moments: lanes xx yy zz xy xz yz
  logic signed [17:0] s_w [3];
  always_comb begin
    for (int a = 0; a < 3; a++)
      s_w[a] = 18'($signed(v_w[0][2-a])) + 18'($signed(v_w[1][2-a]))
             + 18'($signed(v_w[2][2-a])) + 18'($signed(v_w[3][2-a]));
  end
  function automatic logic signed [MomW-1:0] mom(input int a, input int b,
      input tic_vec_t v0, input tic_vec_t v1, input tic_vec_t v2,
      input tic_vec_t v3, input logic signed [17:0] sa,
      input logic signed [17:0] sb);
    return MomW'(sa * sb)
         + MomW'($signed(v0[2-a]) * $signed(v0[2-b]))
         + MomW'($signed(v1[2-a]) * $signed(v1[2-b]))
         + MomW'($signed(v2[2-a]) * $signed(v2[2-b]))
         + MomW'($signed(v3[2-a]) * $signed(v3[2-b]));
  endfunction
  always_ff @(posedge clk_i) begin
    m_q[0] <= mom(0, 0, v_w[0], v_w[1], v_w[2], v_w[3], s_w[0], s_w[0]);
    m_q[1] <= mom(1, 1, v_w[0], v_w[1], v_w[2], v_w[3], s_w[1], s_w[1]);
    m_q[2] <= mom(2, 2, v_w[0], v_w[1], v_w[2], v_w[3], s_w[2], s_w[2]);
    m_q[3] <= mom(0, 1, v_w[0], v_w[1], v_w[2], v_w[3], s_w[0], s_w[1]);
    m_q[4] <= mom(0, 2, v_w[0], v_w[1], v_w[2], v_w[3], s_w[0], s_w[2]);
    m_q[5] <= mom(1, 2, v_w[0], v_w[1], v_w[2], v_w[3], s_w[1], s_w[2]);
  end

  // stage 2: triple product, made absolute in absolute volume mode
  assign t_w = TripW'(d0_q[0] * cr_q[0]) + TripW'(d0_q[1] * cr_q[1])
             + TripW'(d0_q[2] * cr_q[2]);
  always_ff @(posedge clk_i) begin
    t_q <= (abs_q && t_w[TripW-1]) ? -t_w : t_w;
    m2_q <= m_q;
  end

  // volume path delayed alongside the lanes
  localparam int unsigned VDepth = (TripW + 3) / 4;
  localparam int unsigned VPad   = LaneLat - 2 - VDepth;
  logic [TripW-2:0] tm_q;
  logic tn_q;
  logic [TripW-1:0] tv_q;
  logic [VDepth:0] vn_sr_q;
  logic [VolW+5:0] vq_w;
  always_ff @(posedge clk_i) begin
    tm_q <= (TripW-1)'(t_q[TripW-1] ? -t_q : t_q);
    tn_q <= t_q[TripW-1];
    tv_q <= TripW'(tm_q) + TripW'(3);
    vn_sr_q <= {vn_sr_q[VDepth-1:0], tn_q};
  end
  tic_div_const #(.NumW(TripW), .QW(VolW+6), .Den(6)) u_vdiv (
    .clk_i (clk_i), .num_i (tv_q), .quo_o (vq_w)
  );
  // volume divider depth differs; align by extra register stages
  logic [VolW:0] vp_w;
  logic vpn_w;
  logic [VPad-1:0][VolW:0] vp_q;
  logic [VPad-1:0] vpn_q;
  logic signed [VolW:0] vs_w;
  assign vp_w  = (vq_w > (VolW+6)'(48'h7FFFFFFFFFFF)) ? {1'b0, 48'h800000000000}
                                                       : (VolW+1)'(vq_w);
  assign vpn_w = vn_sr_q[VDepth];
  always_ff @(posedge clk_i) begin
    vp_q  <= {vp_q[VPad-2:0], vp_w};
    vpn_q <= {vpn_q[VPad-2:0], vpn_w};
  end
  // magnitude already clipped to 2^47 so negation fits
  always_comb begin
    vs_w = vpn_q[VPad-1] ? -$signed(vp_q[VPad-1]) : $signed(vp_q[VPad-1]);
    if (!vpn_q[VPad-1] && vp_q[VPad-1][VolW-1]) vs_w = (VolW+1)'(48'h7FFFFFFFFFFF);
  end

  // covariance lanes
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    tic_lane u_lane (.clk_i(clk_i), .trip_i(t_q), .mom_i(m2_q[l]), .cov_o(c_w[l]));
  end

  // merge stage
  always_ff @(posedge clk_i) begin
    result_o.volume     <= VolW'(vs_w);
    result_o.inertia_xx <= c_w[1] + c_w[2];
    result_o.inertia_yy <= c_w[0] + c_w[2];
    result_o.inertia_zz <= c_w[0] + c_w[1];
    result_o.inertia_xy <= -c_w[3];
    result_o.inertia_xz <= -c_w[4];
    result_o.inertia_yz <= -c_w[5];
  end
  assign done_o = vld_q[Lat-1];

  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[Lat-2]))
    else $error("done without item");
  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(result_o))
    else $error("unknown result");
endmodule
